[hdl/psdl_pkg.sv]
package psdl_pkg;

	// Field widths fixed by the command and result formats.
	localparam int unsigned PRIO_W   = 16;
	localparam int unsigned HANDLE_W = 8;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_INSERTED = 2'd0,
		STAT_DRAINED  = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	// Command action codes.
	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_DRAIN  = 1'b1
	} action_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_DRAIN
	} state_t;

	// One command beat.
	typedef struct packed {
		logic                       action;
		logic signed [PRIO_W-1:0]   priority_req;
		logic        [HANDLE_W-1:0] handle;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		status_t                    status;
		logic        [HANDLE_W-1:0] out_handle;
		logic signed [PRIO_W-1:0]   out_priority;
		logic                       last;
	} rsp_t;

	// One stored list entry.
	typedef struct packed {
		logic signed [PRIO_W-1:0]   prio;
		logic        [HANDLE_W-1:0] handle;
	} entry_t;

endpackage

[hdl/psdl_store.sv]
module psdl_store #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  psdl_pkg::entry_t           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output psdl_pkg::entry_t           rdata
);

	psdl_pkg::entry_t mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/priority_sorted_draw_list_top.sv]
// Insert: the result comes in the cycle after the command when the list is empty or full;
// otherwise the stored entries are read from the tail down to the insertion point, each
// larger one moving up by one, plus a placement step when the new entry lands at the head.
// Drain: on an empty list the result comes in the cycle after the command, else one beat
// per entry. The list memory has one read and one write port, one entry per cycle; reset
// empties the list at once. Results cannot be stalled; busy holds off the next command.
module priority_sorted_draw_list_top #(
	parameter int unsigned DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  psdl_pkg::cmd_t  cmd,
	output logic            done,
	output psdl_pkg::rsp_t  rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	psdl_pkg::state_t state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    addr_q, raddr;
	psdl_pkg::entry_t new_q;
	logic             accept;

	logic             we;
	logic [AW-1:0]    waddr;
	psdl_pkg::entry_t wdata, rdata;

	logic             done_q, done_d;
	psdl_pkg::rsp_t   rsp_q, rsp_d;

	logic [AW-1:0]    tail;
	logic             greater;

	assign accept  = start && (state_q == psdl_pkg::ST_IDLE);
	assign tail    = AW'(count_q - CW'(1));
	assign greater = $signed(rdata.prio) > $signed(new_q.prio);

	psdl_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psdl_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.action == psdl_pkg::ACT_DRAIN) begin
						if (count_q != '0) state_d = psdl_pkg::ST_DRAIN;
					end else if (count_q != CW'(DEPTH) && count_q != '0) begin
						state_d = psdl_pkg::ST_SCAN;
					end
				end
			end
			psdl_pkg::ST_SCAN: begin
				if (!greater) begin
					state_d = psdl_pkg::ST_IDLE;
				end else if (addr_q == '0) begin
					state_d = psdl_pkg::ST_PLACE;
				end
			end
			psdl_pkg::ST_PLACE: begin
				state_d = psdl_pkg::ST_IDLE;
			end
			psdl_pkg::ST_DRAIN: begin
				if (addr_q == tail) state_d = psdl_pkg::ST_IDLE;
			end
			default: state_d = psdl_pkg::ST_IDLE;
		endcase
	end

	// Memory accesses, count update and result beat.
	always_comb begin
		raddr   = addr_q;
		we      = 1'b0;
		waddr   = addr_q + AW'(1);
		wdata   = new_q;
		count_d = count_q;
		done_d  = 1'b0;
		rsp_d   = '{status: psdl_pkg::STAT_INSERTED, out_handle: '0,
		            out_priority: '0, last: 1'b1};
		unique case (state_q)
			psdl_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.action == psdl_pkg::ACT_DRAIN) begin
						raddr = '0;
						if (count_q == '0) begin
							done_d       = 1'b1;
							rsp_d.status = psdl_pkg::STAT_EMPTY;
						end
					end else if (count_q == CW'(DEPTH)) begin
						done_d       = 1'b1;
						rsp_d.status = psdl_pkg::STAT_FULL;
					end else if (count_q == '0) begin
						// Empty list: the new entry goes straight to the head.
						we                = 1'b1;
						waddr             = '0;
						wdata.prio        = cmd.priority_req;
						wdata.handle      = cmd.handle;
						count_d           = CW'(1);
						done_d            = 1'b1;
					end else begin
						raddr = tail;
					end
				end
			end
			psdl_pkg::ST_SCAN: begin
				// Walk down from the tail, moving larger entries up by one.
				we = 1'b1;
				if (greater) begin
					wdata = rdata;
					raddr = addr_q - AW'(1);
				end else begin
					count_d = count_q + CW'(1);
					done_d  = 1'b1;
				end
			end
			psdl_pkg::ST_PLACE: begin
				we      = 1'b1;
				waddr   = '0;
				count_d = count_q + CW'(1);
				done_d  = 1'b1;
			end
			psdl_pkg::ST_DRAIN: begin
				raddr              = addr_q + AW'(1);
				done_d             = 1'b1;
				rsp_d.status       = psdl_pkg::STAT_DRAINED;
				rsp_d.out_handle   = rdata.handle;
				rsp_d.out_priority = rdata.prio;
				rsp_d.last         = (addr_q == tail);
				if (addr_q == tail) count_d = '0;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psdl_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// Payload registers: address of the entry in flight, the held command, the result.
	always_ff @(posedge clk) begin
		addr_q <= raddr;
		rsp_q  <= rsp_d;
		if (accept) begin
			new_q.prio   <= cmd.priority_req;
			new_q.handle <= cmd.handle;
		end
	end

	assign busy = (state_q != psdl_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[hdl/psdl_checker.sv]
module psdl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input psdl_pkg::rsp_t rsp
);

	// Every beat other than a drained entry ends its command.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != psdl_pkg::STAT_DRAINED |-> rsp.last)
		else $error("non-drain result without last");

	// Non-drain beats carry zero handle and priority.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != psdl_pkg::STAT_DRAINED
		|-> rsp.out_handle == '0 && rsp.out_priority == '0)
		else $error("non-drain result carries payload");

	// An accepted command is either still in work or answered in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command produced neither work nor result");

	// With no command and nothing in work, no beat can appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("spurious result beat");

	// A drain still has more beats to give while last is low.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.last |-> busy)
		else $error("drain stopped before its last beat");

endmodule

bind priority_sorted_draw_list_top psdl_checker u_psdl_checker (.*);
